@@ sv/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/lir_pkg.sv @@
package lir_pkg;

    localparam int RATE_W     = 18;
    localparam int COUNT_W    = 24;
    localparam int OUT_CNT_W  = 28;
    localparam int IDX_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CMUL_W     = COUNT_W + RATE_W;
    localparam int DIV_NUM_W  = CMUL_W + 2;
    localparam int DIV_DEN_W  = RATE_W + 1;
    localparam int DIV_CNT_W  = 6;

    localparam logic [RATE_W-1:0]  INPUT_RATE_RST  = 18'd44100;
    localparam logic [RATE_W-1:0]  OUTPUT_RATE_RST = 18'd96000;
    localparam logic [COUNT_W-1:0] COUNT_RST       = 24'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_RATE   = 2'd0,
        REG_OUTPUT_RATE  = 2'd1,
        REG_SAMPLE_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMUL,
        S_TGO,
        S_TWAIT,
        S_QWAIT,
        S_CHECK,
        S_FWAIT,
        S_IMUL,
        S_EMIT,
        S_PASS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_DEN_W-1:0] init_rem;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ sv/lir_ifs.sv @@
interface lir_sample_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

interface lir_result_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_sample;
    logic                out_last;

    modport source (output valid, output out_sample, output out_last, input ready);
    modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

interface lir_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lir_pkg::CFG_IDX_W-1:0]     index;
    logic [lir_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/lir_div.sv @@
`include "assert_macros.svh"

// restoring divider, one quotient bit per cycle, dividend taken msb first
module lir_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lir_pkg::div_req_t                 req,
    output lir_pkg::div_stat_t                stat,
    output logic [lir_pkg::DIV_NUM_W-1:0]     quo,
    output logic [lir_pkg::DIV_DEN_W-1:0]     rem
);

    localparam int NW = lir_pkg::DIV_NUM_W;
    localparam int DW = lir_pkg::DIV_DEN_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [lir_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [DW-1:0]                 rem_reg;
    logic [DW-1:0]                 den_reg;
    logic [NW-1:0]                 num_reg;
    logic [NW-1:0]                 quo_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[NW-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        ge       = !diff[DW+1];
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == lir_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= req.init_rem;
            den_reg <= req.den;
            num_reg <= req.num;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[NW-2:0], 1'b0};
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

    `ASSERT_IMPLIES(a_no_restart, clk, rst_n, req.start, !busy_reg, "divider started while busy")
    `ASSERT_IMPLIES(a_rem_bound, clk, rst_n, busy_reg, rem_reg < den_reg, "partial remainder not below divisor")

endmodule

@@ sv/linear_interp_resampler.sv @@
// channel   | dir | payload                       | notes
// samples   | in  | in_sample (signed)            | one request per input sample
// results   | out | out_sample (signed), out_last | registered, zero to 34 per sample
// cfg       | in  | index, data                   | 0 input_rate, 1 output_rate, 2 sample_count
//
// pass-through rates: each sample goes through the pass and done states; the next sample is taken only back in idle
// first sample of a burst: extra count multiply, then the output-count and step-split divisions
// each interpolated output: a fraction from the shared serial divider, then the shift-add multiplier
// rst_n clears the registers to their defaults and the burst state; no clearing pass
// a stalled results channel holds the block in the emit or pass state, samples stays low meanwhile

`include "assert_macros.svh"

module linear_interp_resampler #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_RATIO   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    lir_sample_if.sink          samples,
    lir_result_if.source        results,
    lir_cfg_if.sink             cfg
);

    localparam int RATE_W    = lir_pkg::RATE_W;
    localparam int COUNT_W   = lir_pkg::COUNT_W;
    localparam int OUT_CNT_W = lir_pkg::OUT_CNT_W;
    localparam int IDX_W     = lir_pkg::IDX_W;
    localparam int CMUL_W    = lir_pkg::CMUL_W;
    localparam int NUM_W     = lir_pkg::DIV_NUM_W;
    localparam int DEN_W     = lir_pkg::DIV_DEN_W;
    localparam int RATIO_W   = $clog2(MAX_RATIO + 1);
    localparam int CAP_W     = RATE_W + RATIO_W;
    localparam int MAX_OUT   = 2 * MAX_RATIO + 2;
    localparam int N_W       = $clog2(MAX_OUT + 1);
    localparam int STEP_W    = $clog2((FRAC_BITS > RATE_W ? FRAC_BITS : RATE_W) + 1);
    localparam int P_W       = SAMPLE_BITS + 1 + FRAC_BITS;

    // configuration registers
    logic [RATE_W-1:0]  inr_reg;
    logic [RATE_W-1:0]  outr_reg;
    logic [COUNT_W-1:0] cnt_reg;

    // burst state
    lir_pkg::state_t        state_reg;
    lir_pkg::state_t        state_next;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [COUNT_W-1:0]     k_reg;         // index of the current sample in the burst
    logic [OUT_CNT_W-1:0]   emitted_reg;
    logic [OUT_CNT_W-1:0]   total_reg;
    logic [IDX_W-1:0]       nidx_reg;      // source index of the next output
    logic [RATE_W-1:0]      nrem_reg;      // source phase remainder of the next output
    logic                   last_reg;
    logic                   rep_reg;       // next output repeats the final sample
    logic [N_W-1:0]         n_reg;
    logic [STEP_W-1:0]      step_reg;

    // payload
    logic [SAMPLE_BITS-1:0] cur_reg;
    logic [RATE_W-1:0]      q_reg;         // whole source steps per output
    logic [RATE_W-1:0]      r_reg;         // fractional source step per output
    logic [RATE_W-1:0]      outr_sr;
    logic [FRAC_BITS-1:0]   frac_sr;
    logic [CMUL_W-1:0]      cmul_acc_reg;
    logic [P_W-1:0]         imul_acc_reg;

    // output register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_last_reg;

    lir_pkg::div_req_t         div_req;
    lir_pkg::div_stat_t        div_stat;
    logic [NUM_W-1:0]          div_quo;
    logic [DEN_W-1:0]          div_rem;

    logic                      in_acc;
    logic                      cfg_acc;
    logic                      zero_cfg;
    logic [CAP_W-1:0]          cap;
    logic [RATE_W-1:0]         outr_eff;
    logic                      is_pass;
    logic                      last_in;
    logic                      more;
    logic                      interp;
    logic                      slot_free;
    logic                      emit_load;
    logic                      emit_is_last;
    logic [NUM_W-1:0]          tot_num;
    logic [CMUL_W-1:0]         cmul_acc_next;
    logic [SAMPLE_BITS:0]      diff;
    logic [P_W-1:0]            imul_acc_next;
    logic [SAMPLE_BITS:0]      interp_sum;
    logic [RATE_W:0]           nrem_sum;
    logic                      wrap;
    logic [RATE_W-1:0]         nrem_adv;
    logic [IDX_W-1:0]          nidx_adv;

    // ratio clamp, rate compare and burst bookkeeping
    always_comb
    begin
        in_acc    = samples.valid && samples.ready;
        cfg_acc   = cfg.valid && cfg.ready;
        zero_cfg  = (inr_reg == '0) || (outr_reg == '0) || (cnt_reg == '0);
        cap       = CAP_W'(inr_reg) * CAP_W'(MAX_RATIO);
        outr_eff  = (CAP_W'(outr_reg) > cap) ? cap[RATE_W-1:0] : outr_reg;
        is_pass   = (inr_reg == outr_eff);
        last_in   = ({1'b0, k_reg} + 1'b1) >= {1'b0, cnt_reg};
        more      = (emitted_reg < total_reg) && (n_reg < N_W'(MAX_OUT));
        interp    = nidx_reg < IDX_W'(k_reg);
        slot_free = !out_valid_reg || results.ready;
        emit_load = slot_free
                    && ((state_reg == lir_pkg::S_EMIT) || (state_reg == lir_pkg::S_PASS));
        emit_is_last = (emitted_reg + 1'b1) == total_reg;
    end

    // serial arithmetic: count multiply, interpolation multiply, phase advance
    always_comb
    begin
        // round-half-up numerator 2*count*rate + input rate
        tot_num       = NUM_W'({cmul_acc_reg, 1'b0}) + NUM_W'(inr_reg);
        cmul_acc_next = {cmul_acc_reg[CMUL_W-2:0], 1'b0}
                        + (outr_sr[RATE_W-1] ? CMUL_W'(cnt_reg) : CMUL_W'(0));
        diff          = {cur_reg[SAMPLE_BITS-1], cur_reg} - {prev_reg[SAMPLE_BITS-1], prev_reg};
        imul_acc_next = {imul_acc_reg[P_W-2:0], 1'b0}
                        + (frac_sr[FRAC_BITS-1] ? {{FRAC_BITS{diff[SAMPLE_BITS]}}, diff}
                                                : P_W'(0));
        // arithmetic shift right by FRAC_BITS is the upper slice of the product
        interp_sum    = {prev_reg[SAMPLE_BITS-1], prev_reg} + imul_acc_reg[P_W-1:FRAC_BITS];
        nrem_sum      = {1'b0, nrem_reg} + {1'b0, r_reg};
        wrap          = nrem_sum >= {1'b0, outr_eff};
        nrem_adv      = wrap ? RATE_W'(nrem_sum - {1'b0, outr_eff}) : nrem_sum[RATE_W-1:0];
        nidx_adv      = nidx_reg + IDX_W'(q_reg) + IDX_W'(wrap);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lir_pkg::S_IDLE:
            begin
                if (in_acc && !zero_cfg)
                begin
                    if (is_pass)
                        state_next = lir_pkg::S_PASS;
                    else if (k_reg == '0)
                        state_next = lir_pkg::S_CMUL;
                    else
                        state_next = lir_pkg::S_CHECK;
                end
            end
            lir_pkg::S_CMUL:
            begin
                if (step_reg == STEP_W'(1))
                    state_next = lir_pkg::S_TGO;
            end
            lir_pkg::S_TGO:
                state_next = lir_pkg::S_TWAIT;
            lir_pkg::S_TWAIT:
            begin
                if (div_stat.done)
                    state_next = lir_pkg::S_QWAIT;
            end
            lir_pkg::S_QWAIT:
            begin
                if (div_stat.done)
                    state_next = lir_pkg::S_CHECK;
            end
            lir_pkg::S_CHECK:
            begin
                priority if (more && interp)
                    state_next = lir_pkg::S_FWAIT;
                else if (more && last_reg)
                    state_next = lir_pkg::S_EMIT;
                else
                    state_next = lir_pkg::S_DONE;
            end
            lir_pkg::S_FWAIT:
            begin
                if (div_stat.done)
                    state_next = lir_pkg::S_IMUL;
            end
            lir_pkg::S_IMUL:
            begin
                if (step_reg == STEP_W'(1))
                    state_next = lir_pkg::S_EMIT;
            end
            lir_pkg::S_EMIT:
            begin
                if (slot_free)
                    state_next = lir_pkg::S_CHECK;
            end
            lir_pkg::S_PASS:
            begin
                if (slot_free)
                    state_next = lir_pkg::S_DONE;
            end
            lir_pkg::S_DONE:
                state_next = lir_pkg::S_IDLE;
            default:
                state_next = lir_pkg::S_IDLE;
        endcase
    end

    // divider requests: output count, step split, then one fraction per interpolated output
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.steps    = lir_pkg::DIV_CNT_W'(FRAC_BITS);
        div_req.num      = '0;
        div_req.den      = {1'b0, outr_eff};
        div_req.init_rem = {1'b0, nrem_reg};
        unique case (state_reg)
            lir_pkg::S_TGO:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = lir_pkg::DIV_CNT_W'(NUM_W);
                div_req.num      = tot_num;
                div_req.den      = {inr_reg, 1'b0};
                div_req.init_rem = '0;
            end
            lir_pkg::S_TWAIT:
            begin
                div_req.start    = div_stat.done;
                div_req.steps    = lir_pkg::DIV_CNT_W'(RATE_W);
                div_req.num      = {inr_reg, (NUM_W - RATE_W)'(0)};
                div_req.init_rem = '0;
            end
            lir_pkg::S_CHECK:
                div_req.start = more && interp;
            default:
                div_req.start = 1'b0;
        endcase
    end

    lir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // control and burst state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lir_pkg::S_IDLE;
            inr_reg       <= lir_pkg::INPUT_RATE_RST;
            outr_reg      <= lir_pkg::OUTPUT_RATE_RST;
            cnt_reg       <= lir_pkg::COUNT_RST;
            prev_reg      <= '0;
            k_reg         <= '0;
            emitted_reg   <= '0;
            total_reg     <= '0;
            nidx_reg      <= '0;
            nrem_reg      <= '0;
            last_reg      <= 1'b0;
            rep_reg       <= 1'b0;
            n_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                unique case (lir_pkg::cfg_reg_t'(cfg.index))
                    lir_pkg::REG_INPUT_RATE:   inr_reg  <= cfg.data[RATE_W-1:0];
                    lir_pkg::REG_OUTPUT_RATE:  outr_reg <= cfg.data[RATE_W-1:0];
                    lir_pkg::REG_SAMPLE_COUNT: cnt_reg  <= cfg.data[COUNT_W-1:0];
                    default:                   inr_reg  <= inr_reg;
                endcase
                // any valid register write ends the burst
                if (cfg.index != lir_pkg::CFG_IDX_W'(3))
                begin
                    prev_reg    <= '0;
                    k_reg       <= '0;
                    emitted_reg <= '0;
                    total_reg   <= '0;
                    nidx_reg    <= '0;
                    nrem_reg    <= '0;
                end
            end

            unique case (state_reg)
                lir_pkg::S_IDLE:
                begin
                    if (in_acc && !zero_cfg)
                    begin
                        last_reg <= last_in;
                        n_reg    <= '0;
                        step_reg <= STEP_W'(RATE_W);
                    end
                end
                lir_pkg::S_CMUL:
                    step_reg <= step_reg - 1'b1;
                lir_pkg::S_TWAIT:
                begin
                    if (div_stat.done)
                        total_reg <= div_quo[OUT_CNT_W-1:0];
                end
                lir_pkg::S_CHECK:
                    rep_reg <= !interp;
                lir_pkg::S_FWAIT:
                    step_reg <= STEP_W'(FRAC_BITS);
                lir_pkg::S_IMUL:
                    step_reg <= step_reg - 1'b1;
                lir_pkg::S_EMIT:
                begin
                    if (slot_free)
                    begin
                        emitted_reg <= emitted_reg + 1'b1;
                        nidx_reg    <= nidx_adv;
                        nrem_reg    <= nrem_adv;
                        n_reg       <= n_reg + 1'b1;
                    end
                end
                lir_pkg::S_DONE:
                begin
                    if (last_reg)
                    begin
                        prev_reg    <= '0;
                        k_reg       <= '0;
                        emitted_reg <= '0;
                        total_reg   <= '0;
                        nidx_reg    <= '0;
                        nrem_reg    <= '0;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        k_reg    <= k_reg + 1'b1;
                    end
                end
                default:
                    step_reg <= step_reg;
            endcase

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_reg      <= samples.in_sample;
            cmul_acc_reg <= '0;
            outr_sr      <= outr_eff;
        end
        else if (state_reg == lir_pkg::S_CMUL)
        begin
            cmul_acc_reg <= cmul_acc_next;
            outr_sr      <= {outr_sr[RATE_W-2:0], 1'b0};
        end

        if ((state_reg == lir_pkg::S_QWAIT) && div_stat.done)
        begin
            q_reg <= div_quo[RATE_W-1:0];
            r_reg <= div_rem[RATE_W-1:0];
        end

        if ((state_reg == lir_pkg::S_FWAIT) && div_stat.done)
        begin
            frac_sr      <= div_quo[FRAC_BITS-1:0];
            imul_acc_reg <= '0;
        end
        else if (state_reg == lir_pkg::S_IMUL)
        begin
            frac_sr      <= {frac_sr[FRAC_BITS-2:0], 1'b0};
            imul_acc_reg <= imul_acc_next;
        end

        if (emit_load)
        begin
            if ((state_reg == lir_pkg::S_PASS) || rep_reg)
                out_sample_reg <= cur_reg;
            else
                out_sample_reg <= interp_sum[SAMPLE_BITS-1:0];
            out_last_reg <= (state_reg == lir_pkg::S_PASS) ? last_reg : emit_is_last;
        end
    end

    // port drive
    assign samples.ready      = (state_reg == lir_pkg::S_IDLE) && !cfg.valid;
    assign cfg.ready          = (state_reg == lir_pkg::S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_sample_reg;
    assign results.out_last   = out_last_reg;

    `ASSERT_ALWAYS(a_emit_bound, clk, rst_n, emitted_reg <= total_reg, "more outputs than the burst total")
    `ASSERT_ALWAYS(a_step_cap, clk, rst_n, n_reg <= N_W'(MAX_OUT), "per-sample output cap exceeded")
    `ASSERT_IMPLIES(a_phase_bound, clk, rst_n, state_reg == lir_pkg::S_CHECK, nrem_reg < outr_eff, "phase remainder reached the output rate")

endmodule
